/* rtl/swm_pkg.sv */
package swm_pkg;

    localparam int PATTERN_LEN = 32;
    localparam int LEN_W = $clog2(PATTERN_LEN + 1);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_WILDCARD = '0;

    localparam logic [7:0] WILDCARD_RESET = 8'd42;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_LOAD = 2'd0;
    localparam cmd_t CMD_TEXT = 2'd1;
    localparam cmd_t CMD_END  = 2'd2;

    typedef logic [LEN_W-1:0] len_t;

    typedef struct packed {
        logic       text_en;
        logic       rearm;
        logic       clear_pat;
        logic [7:0] ch;
        logic [7:0] wc;
    } cell_ctrl_t;

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

endpackage

/* rtl/swm_item_if.sv */
interface swm_item_if;
    import swm_pkg::*;

    logic       valid;
    logic       ready;
    cmd_t       cmd;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output cmd, output ch, output last, input ready);
    modport sink (input valid, input cmd, input ch, input last, output ready);

endinterface

/* rtl/swm_verdict_if.sv */
interface swm_verdict_if;

    logic valid;
    logic ready;
    logic matched;
    logic overflow;

    modport source (output valid, output matched, output overflow, input ready);
    modport sink (input valid, input matched, input overflow, output ready);

endinterface

/* rtl/swm_cell.sv */
module swm_cell
    import swm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       wr,
    input  logic       rearm_val,
    input  logic       prop_in,
    input  logic       step_in,
    output logic       prop_out,
    output logic       step_out,
    output logic       closed
);

    logic [7:0] char_reg;
    logic       in_pat_reg;
    logic       in_pat_next;
    logic       active_reg;
    logic       active_next;
    logic       is_wc;

    assign is_wc    = in_pat_reg && (char_reg == ctrl.wc);
    assign closed   = active_reg | prop_in;
    assign prop_out = closed & is_wc;
    assign step_out = closed & in_pat_reg & ~is_wc & (char_reg == ctrl.ch);

    always_comb
    begin
        active_next = active_reg;
        if (ctrl.rearm)
        begin
            active_next = rearm_val;
        end
        else if (ctrl.text_en)
        begin
            active_next = (closed & is_wc) | step_in;
        end
        in_pat_next = ctrl.clear_pat ? wr : (in_pat_reg | wr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_pat_reg <= 1'b0;
            active_reg <= rearm_val;
        end
        else
        begin
            in_pat_reg <= in_pat_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            char_reg <= ctrl.ch;
        end
    end

endmodule

/* rtl/swm_out_buf.sv */
module swm_out_buf
    import swm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  verdict_t      res,
    output logic          space,
    swm_verdict_if.source verdicts
);

    logic     out_valid_reg;
    logic     out_valid_next;
    verdict_t out_data_reg;
    verdict_t out_data_next;
    logic     skid_valid_reg;
    logic     skid_valid_next;
    verdict_t skid_data_reg;
    verdict_t skid_data_next;
    logic     pop;

    assign pop               = out_valid_reg & verdicts.ready;
    assign space             = ~skid_valid_reg;
    assign verdicts.valid    = out_valid_reg;
    assign verdicts.matched  = out_data_reg.matched;
    assign verdicts.overflow = out_data_reg.overflow;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = res;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = res;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

/* rtl/star_wildcard_matcher.sv */
// Channel    Direction  Payload                Transfer
// items      in         cmd[1:0] ch[7:0] last  valid & ready
// verdicts   out        matched overflow       valid & ready
// apb        in         wildcard register      psel & penable & pwrite
//
// One item is taken every cycle unless the buffer is full; a row of cells updates all
// pattern positions at once. Verdicts are registered in the output or skid register.
// A two-entry output buffer lets items keep flowing while a verdict waits.
// Reset takes effect at once and needs no clearing pass.
module star_wildcard_matcher
    import swm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    swm_item_if.sink           items,
    swm_verdict_if.source      verdicts,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [7:0] wc_reg;
    len_t       len_reg;
    len_t       len_next;
    len_t       len_eff;
    logic       complete_reg;
    logic       complete_next;
    logic       ovf_reg;
    logic       ovf_next;
    logic [7:0] last_char_reg;

    logic       take;
    logic       load;
    logic       dup;
    logic       fits;
    logic       store;
    logic       space;
    logic       cfg_wr;
    logic       reg_hit;
    cell_ctrl_t ctrl;
    verdict_t   res;

    logic [PATTERN_LEN-1:0] wr;
    logic [PATTERN_LEN-1:0] prop;
    logic [PATTERN_LEN-1:0] step;
    logic [PATTERN_LEN:0]   closed;
    logic [PATTERN_LEN:0]   at_end;
    logic                   final_reg;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_WILDCARD);
    assign cfg_wr  = psel & penable & pwrite & reg_hit;
    assign prdata  = reg_hit ? {{(PDATA_W-8){1'b0}}, wc_reg} : '0;

    assign items.ready = space;
    assign take        = items.valid & space;
    assign load        = take && (items.cmd == CMD_LOAD);

    assign len_eff = complete_reg ? '0 : len_reg;
    assign dup     = (items.ch == wc_reg) && (len_eff != '0) && (last_char_reg == wc_reg);
    assign fits    = (len_eff < len_t'(PATTERN_LEN));
    assign store   = load & ~dup & fits;

    assign ctrl.text_en   = take && (items.cmd == CMD_TEXT);
    assign ctrl.rearm     = load || (take && (items.cmd == CMD_END));
    assign ctrl.clear_pat = load & complete_reg;
    assign ctrl.ch        = items.ch;
    assign ctrl.wc        = wc_reg;

    genvar gi;
    generate
        for (gi = 0; gi < PATTERN_LEN; gi++)
        begin : g_cell
            assign wr[gi] = store && (len_eff == len_t'(gi));

            swm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .wr        (wr[gi]),
                .rearm_val ((gi == 0) ? 1'b1 : 1'b0),
                .prop_in   ((gi == 0) ? 1'b0 : prop[(gi == 0) ? 0 : gi-1]),
                .step_in   ((gi == 0) ? 1'b0 : step[(gi == 0) ? 0 : gi-1]),
                .prop_out  (prop[gi]),
                .step_out  (step[gi]),
                .closed    (closed[gi])
            );
        end
        for (gi = 0; gi <= PATTERN_LEN; gi++)
        begin : g_end
            assign at_end[gi] = (len_reg == len_t'(gi));
        end
    endgenerate

    assign closed[PATTERN_LEN] = final_reg | prop[PATTERN_LEN-1];

    assign res.matched  = |(closed & at_end);
    assign res.overflow = ovf_reg;

    always_comb
    begin
        len_next      = len_reg;
        complete_next = complete_reg;
        ovf_next      = ovf_reg;
        if (load)
        begin
            len_next      = len_eff + len_t'(store);
            complete_next = items.last;
            ovf_next      = (ovf_reg & ~complete_reg) | (~dup & ~fits);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg       <= WILDCARD_RESET;
            len_reg      <= '0;
            complete_reg <= 1'b0;
            ovf_reg      <= 1'b0;
            final_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                wc_reg <= pwdata[7:0];
            end
            len_reg      <= len_next;
            complete_reg <= complete_next;
            ovf_reg      <= ovf_next;
            if (ctrl.rearm)
            begin
                final_reg <= 1'b0;
            end
            else if (ctrl.text_en)
            begin
                final_reg <= step[PATTERN_LEN-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            last_char_reg <= items.ch;
        end
    end

    swm_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (take && (items.cmd == CMD_END)),
        .res      (res),
        .space    (space),
        .verdicts (verdicts)
    );

endmodule

/* tb/tb_top.sv */
module tb_top;
    import swm_pkg::*;

    localparam cmd_t CMD_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int N_PHASES = 6;
    localparam int N_DIR = 24;
    localparam int MAX_PRINTED = 100;

    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_C = 8'h63;
    localparam logic [7:0] CH_X = 8'h78;
    localparam logic [7:0] CH_STAR = 8'h2A;

    localparam logic [PATTERN_LEN:0] LIVE_START = {{PATTERN_LEN{1'b0}}, 1'b1};

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] ch;
        logic       last;
        logic [7:0] reps;
        logic       fixed;
        verdict_t   want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    swm_item_if    item_ch();
    swm_verdict_if verdict_ch();

    star_wildcard_matcher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (item_ch),
        .verdicts (verdict_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Typed expectations travel alongside the payload of each transfer.
    logic     want_fixed;
    verdict_t want_v;

    logic [7:0]           wc_model = WILDCARD_RESET;
    logic [7:0]           pat_mem [PATTERN_LEN];
    int                   pat_len = 0;
    bit                   pat_done = 1'b0;
    bit                   pat_ovf = 1'b0;
    logic [PATTERN_LEN:0] live = LIVE_START;

    verdict_t   verdicts_due [$];
    logic [7:0] loaded_pat [$];
    int         items_sent = 0;
    int         errors = 0;
    int         cycles = 0;
    bit         calm = 1'b0;

    stim_row_t dir_rows [N_DIR] = '{
        '{CMD_END,  8'h00,   1'b0, 8'd1,  1'b1, 2'b10},
        '{CMD_TEXT, CH_A,    1'b0, 8'd1,  1'b0, 2'b00},
        '{CMD_END,  8'h00,   1'b0, 8'd1,  1'b1, 2'b00},
        '{CMD_LOAD, CH_A,    1'b0, 8'd1,  1'b0, 2'b00},
        '{CMD_LOAD, CH_STAR, 1'b0, 8'd2,  1'b0, 2'b00},
        '{CMD_LOAD, CH_C,    1'b1, 8'd1,  1'b0, 2'b00},
        '{CMD_TEXT, CH_A,    1'b0, 8'd1,  1'b0, 2'b00},
        '{CMD_TEXT, 8'hFF,   1'b0, 8'd1,  1'b0, 2'b00},
        '{CMD_TEXT, CH_C,    1'b0, 8'd1,  1'b0, 2'b00},
        '{CMD_END,  8'h00,   1'b0, 8'd1,  1'b0, 2'b00},
        '{CMD_NONE, 8'hFF,   1'b1, 8'd1,  1'b0, 2'b00},
        '{CMD_END,  8'h00,   1'b0, 8'd1,  1'b0, 2'b00},
        '{CMD_LOAD, CH_X,    1'b0, 8'd34, 1'b0, 2'b00},
        '{CMD_LOAD, CH_X,    1'b1, 8'd1,  1'b0, 2'b00},
        '{CMD_END,  8'h00,   1'b0, 8'd1,  1'b1, 2'b01},
        '{CMD_LOAD, CH_STAR, 1'b1, 8'd1,  1'b0, 2'b00},
        '{CMD_END,  8'h00,   1'b0, 8'd1,  1'b1, 2'b10},
        '{CMD_LOAD, 8'h00,   1'b0, 8'd1,  1'b0, 2'b00},
        '{CMD_TEXT, 8'h00,   1'b0, 8'd1,  1'b0, 2'b00},
        '{CMD_END,  8'h00,   1'b0, 8'd1,  1'b0, 2'b00},
        '{CMD_LOAD, 8'hFF,   1'b1, 8'd1,  1'b0, 2'b00},
        '{CMD_TEXT, 8'h00,   1'b0, 8'd1,  1'b0, 2'b00},
        '{CMD_TEXT, 8'hFF,   1'b0, 8'd1,  1'b0, 2'b00},
        '{CMD_END,  8'hFF,   1'b1, 8'd1,  1'b0, 2'b10}
    };

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic flag_mismatch(input string what);
        if (errors < MAX_PRINTED)
            $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    // Wildcards may match nothing, so activity spreads across them.
    function automatic void spread_over_wildcards();
        for (int i = 0; i < pat_len; i++)
        begin
            if (live[i] && pat_mem[i] == wc_model)
                live[i + 1] = 1'b1;
        end
    endfunction

    function automatic bit glob_step(input cmd_t c, input logic [7:0] ch, input logic l,
                                     output verdict_t v);
        logic [PATTERN_LEN:0] nxt;
        v = '0;
        nxt = '0;
        case (c)
            CMD_LOAD:
            begin
                if (pat_done)
                begin
                    pat_len = 0;
                    pat_ovf = 1'b0;
                    pat_done = 1'b0;
                end
                if (ch == wc_model && pat_len > 0 && pat_mem[pat_len - 1] == wc_model)
                    pat_len = pat_len;
                else if (pat_len < PATTERN_LEN)
                begin
                    pat_mem[pat_len] = ch;
                    pat_len++;
                end
                else
                    pat_ovf = 1'b1;
                if (l)
                    pat_done = 1'b1;
                live = LIVE_START;
                return 1'b0;
            end
            CMD_TEXT:
            begin
                spread_over_wildcards();
                for (int i = 0; i < pat_len; i++)
                begin
                    if (live[i])
                    begin
                        if (pat_mem[i] == wc_model)
                            nxt[i] = 1'b1;
                        else if (pat_mem[i] == ch)
                            nxt[i + 1] = 1'b1;
                    end
                end
                live = nxt;
                return 1'b0;
            end
            CMD_END:
            begin
                spread_over_wildcards();
                v.matched = live[pat_len];
                v.overflow = pat_ovf;
                live = LIVE_START;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    always @(posedge clk)
    begin : watch
        verdict_t exp_v;
        verdict_t pred_v;
        if (rst_n)
        begin
            if (verdict_ch.valid && verdict_ch.ready)
            begin
                if (verdicts_due.size() == 0)
                    flag_mismatch("verdict transfer with no verdict pending");
                else
                begin
                    exp_v = verdicts_due.pop_front();
                    if (verdict_ch.matched !== exp_v.matched)
                        flag_mismatch($sformatf("matched %b, predicted %b",
                                                verdict_ch.matched, exp_v.matched));
                    if (verdict_ch.overflow !== exp_v.overflow)
                        flag_mismatch($sformatf("overflow %b, predicted %b",
                                                verdict_ch.overflow, exp_v.overflow));
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                if (glob_step(item_ch.cmd, item_ch.ch, item_ch.last, pred_v))
                    verdicts_due.push_back(want_fixed ? want_v : pred_v);
            end
        end
    end

    always @(posedge clk)
    begin
        verdict_ch.ready <= calm || ($urandom_range(99) >= 31);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_item(input cmd_t c, input logic [7:0] ch, input logic l,
                             input logic fx, input verdict_t fv);
        while (!calm && $urandom_range(99) < 31)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.cmd <= c;
        item_ch.ch <= ch;
        item_ch.last <= l;
        want_fixed <= fx;
        want_v <= fv;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic settle(input int extra);
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_wildcard(input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_WILDCARD, 2'b00};
        pwdata <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        wc_model = value;
    endtask

    function automatic logic [7:0] pick_letter();
        return CH_A + 8'($urandom_range(2));
    endfunction

    function automatic logic [7:0] pick_pattern_char();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return wc_model;
        if (r < 35)
            return 8'($urandom_range(255));
        return pick_letter();
    endfunction

    function automatic logic [7:0] pick_text_char();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 8'($urandom_range(255));
        if (r < 10)
            return wc_model;
        return pick_letter();
    endfunction

    // Mostly a pattern followed by texts that tend to fit it; some noise and broken runs.
    task automatic run_sequence();
        int         plen;
        int         r;
        logic [7:0] c;
        logic       l;
        if ($urandom_range(99) < 8)
        begin
            repeat ($urandom_range(6, 1))
                send_item(cmd_t'($urandom_range(3)), 8'($urandom_range(255)),
                          1'($urandom_range(1)), 1'b0, '0);
            return;
        end
        if (loaded_pat.size() == 0 || $urandom_range(99) < 80)
        begin
            r = $urandom_range(99);
            if (r < 90)
                plen = $urandom_range(8, 1);
            else if (r < 97)
                plen = $urandom_range(31, 9);
            else
                plen = $urandom_range(40, 32);
            loaded_pat = {};
            for (int k = 0; k < plen; k++)
            begin
                c = pick_pattern_char();
                if (k == plen - 1)
                    l = ($urandom_range(9) != 0);
                else
                    l = ($urandom_range(49) == 0);
                send_item(CMD_LOAD, c, l, 1'b0, '0);
                loaded_pat.push_back(c);
            end
        end
        repeat ($urandom_range(3, 1))
        begin
            if ($urandom_range(99) < 60)
            begin
                foreach (loaded_pat[k])
                begin
                    if (loaded_pat[k] == wc_model)
                    begin
                        repeat ($urandom_range(3))
                            send_item(CMD_TEXT, pick_letter(), 1'($urandom_range(1)),
                                      1'b0, '0);
                    end
                    else if ($urandom_range(99) < 5)
                        send_item(CMD_TEXT, pick_letter(), 1'b0, 1'b0, '0);
                    else
                        send_item(CMD_TEXT, loaded_pat[k], 1'b0, 1'b0, '0);
                end
            end
            else
            begin
                repeat ($urandom_range(8))
                    send_item(CMD_TEXT, pick_text_char(), 1'b0, 1'b0, '0);
            end
            if ($urandom_range(99) >= 4)
                send_item(CMD_END, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'b0, '0);
        end
    endtask

    initial
    begin : stimulus
        int         dir_items;
        int         target;
        logic [7:0] wc;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        item_ch.valid <= 1'b0;
        item_ch.cmd <= CMD_LOAD;
        item_ch.ch <= 8'h00;
        item_ch.last <= 1'b0;
        want_fixed <= 1'b0;
        want_v <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_wildcard(WILDCARD_RESET);
        @(posedge clk);

        for (int r = 0; r < N_DIR; r++)
        begin
            for (int k = 0; k < dir_rows[r].reps; k++)
                send_item(dir_rows[r].cmd, dir_rows[r].ch, dir_rows[r].last,
                          dir_rows[r].fixed, dir_rows[r].want);
        end
        dir_items = items_sent;

        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0: wc = WILDCARD_RESET;
                1: wc = 8'h00;
                2: wc = 8'hFF;
                3: wc = CH_B;
                4: wc = 8'($urandom_range(255));
                default: wc = WILDCARD_RESET;
            endcase
            settle(3);
            calm = (p == 2);
            write_wildcard(wc);
            target = dir_items + (p + 1) * RANDOM_ITEMS / N_PHASES;
            while (items_sent < target)
                run_sequence();
        end

        settle(8);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/swm_pkg.sv
rtl/swm_item_if.sv
rtl/swm_verdict_if.sv
rtl/swm_cell.sv
rtl/swm_out_buf.sv
rtl/star_wildcard_matcher.sv
tb/tb_top.sv
